// ===== rtl/core/sqd_pkg.sv =====
// ----------------------------------------------------------------------------
// sqd_pkg
// Shared types and constants of the shortest-queue dispatcher: action and
// status codes, the command passed from front to back, and the result beat.
// ----------------------------------------------------------------------------
package sqd_pkg;

  localparam int NUM_QUEUES  = 3;
  localparam int QIDX_W      = 2;
  localparam int TAG_W       = 32;
  localparam int MERIT_W     = 16;
  localparam int ENTRY_W     = TAG_W + MERIT_W;
  localparam int FILL_W      = 5;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 72;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_DRAIN = 2'd1,
    ACT_PEEK  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_REJECTED = 3'd1,
    ST_DRAINED  = 3'd2,
    ST_PEEK_HIT = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_PEEK_WAIT,
    B_DRAIN_RD,
    B_DRAIN_WAIT
  } back_state_t;

  typedef struct packed {
    action_t             act;
    logic [TAG_W-1:0]    tag;
    logic [MERIT_W-1:0]  merit;
    logic [QIDX_W-1:0]   sel;
  } cmd_t;

  typedef struct packed {
    status_t             status;
    logic [QIDX_W-1:0]   qidx;
    logic [TAG_W-1:0]    tag;
    logic [MERIT_W-1:0]  merit;
    logic [FILL_W-1:0]   fill0;
    logic [FILL_W-1:0]   fill1;
    logic [FILL_W-1:0]   fill2;
    logic                last;
  } result_t;

endpackage

// ===== rtl/core/sqd_ram.sv =====
// ----------------------------------------------------------------------------
// sqd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sqd_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/sqd_front.sv =====
// ----------------------------------------------------------------------------
// sqd_front
// Accepts input beats, drops unknown actions and holds up to two commands
// for the back end.
// ----------------------------------------------------------------------------
module sqd_front import sqd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  cmd_t in_cmd,
  output logic cmd_valid,
  output cmd_t cmd,
  input  logic cmd_pop
);

  cmd_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  assign in_ready  = (cnt_r != 2'd2);
  assign push      = in_valid && in_ready && (in_cmd.act != ACT_NONE);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = cmd_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, cmd_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_cmd;
    end
  end

`ifndef ASSERT_OFF
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cmd_valid) else $error("command popped from empty queue");
`endif

endmodule

// ===== rtl/core/sqd_back.sv =====
// ----------------------------------------------------------------------------
// sqd_back
// Executes commands against three circular queues kept in one entry RAM,
// and drives the registered result beat.
// ----------------------------------------------------------------------------
module sqd_back import sqd_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    cmd_valid,
  input  cmd_t    cmd,
  output logic    cmd_pop,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t result
);

  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W  = PTR_W + 1;
  localparam int RAM_D  = NUM_QUEUES * QUEUE_DEPTH;
  localparam int ADDR_W = $clog2(RAM_D);

  back_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]   fill_r [NUM_QUEUES];
  logic [CNT_W-1:0]   fill_nxt [NUM_QUEUES];
  logic [PTR_W-1:0]   head_r [NUM_QUEUES];
  logic [PTR_W-1:0]   head_nxt [NUM_QUEUES];
  logic [QIDX_W-1:0]  cur_q_r, cur_q_nxt;
  logic [QIDX_W-1:0]  peek_sel_r, peek_sel_nxt;
  logic               peek_hit_r, peek_hit_nxt;
  logic               out_valid_r, out_valid_nxt;
  result_t            res_r, res_nxt;

  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  logic               out_free, all_empty, add_full, load;
  logic [QIDX_W-1:0]  add_q, first_q, q_step1, q_step2, next_q;
  logic [SUM_W-1:0]   add_sum;
  logic [PTR_W-1:0]   add_slot;

  function automatic logic [ADDR_W-1:0] entry_addr(logic [QIDX_W-1:0] q,
                                                   logic [PTR_W-1:0] slot);
    return ADDR_W'(q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(slot);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  sqd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RAM_D)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free  = !out_valid_r || out_ready;
  assign all_empty = (fill_r[0] == '0) && (fill_r[1] == '0) && (fill_r[2] == '0);

  // Shortest queue, ties to the lower index.
  always_comb begin
    add_q = 2'd0;
    if (fill_r[1] < fill_r[0]) begin
      add_q = 2'd1;
    end
    if (fill_r[2] < fill_r[add_q]) begin
      add_q = 2'd2;
    end
    add_full = (fill_r[add_q] == CNT_W'(QUEUE_DEPTH));
    add_sum  = {1'b0, head_r[add_q]} + SUM_W'(fill_r[add_q]);
    add_slot = (add_sum >= SUM_W'(QUEUE_DEPTH)) ?
               PTR_W'(add_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(add_sum);
  end

  // Round-robin walk: next nonempty queue after the current one.
  always_comb begin
    first_q = (fill_r[0] != '0) ? 2'd0 : ((fill_r[1] != '0) ? 2'd1 : 2'd2);
    q_step1 = (cur_q_r == 2'd2) ? 2'd0 : cur_q_r + 2'd1;
    q_step2 = (q_step1 == 2'd2) ? 2'd0 : q_step1 + 2'd1;
    next_q  = (fill_r[q_step1] != '0) ? q_step1 :
              ((fill_r[q_step2] != '0) ? q_step2 : cur_q_r);
  end

  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    head_nxt     = head_r;
    cur_q_nxt    = cur_q_r;
    peek_sel_nxt = peek_sel_r;
    peek_hit_nxt = peek_hit_r;
    res_nxt      = res_r;
    cmd_pop      = 1'b0;
    load         = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = entry_addr(add_q, add_slot);
    ram_wdata    = {cmd.tag, cmd.merit};
    ram_raddr    = entry_addr(cur_q_r, head_r[cur_q_r]);

    case (state_r)
      B_IDLE: begin
        if (cmd_valid) begin
          case (cmd.act)
            ACT_ADD: begin
              if (out_free) begin
                cmd_pop = 1'b1;
                load    = 1'b1;
                res_nxt = '0;
                if (add_full) begin
                  res_nxt.status = ST_REJECTED;
                end else begin
                  ram_we          = 1'b1;
                  fill_nxt[add_q] = fill_r[add_q] + 1'b1;
                  res_nxt.status  = ST_ADDED;
                  res_nxt.qidx    = add_q;
                end
                res_nxt.last = 1'b1;
              end
            end
            ACT_DRAIN: begin
              if (all_empty) begin
                if (out_free) begin
                  cmd_pop        = 1'b1;
                  load           = 1'b1;
                  res_nxt        = '0;
                  res_nxt.status = ST_EMPTY;
                  res_nxt.last   = 1'b1;
                end
              end else begin
                cmd_pop   = 1'b1;
                cur_q_nxt = first_q;
                state_nxt = B_DRAIN_RD;
              end
            end
            ACT_PEEK: begin
              cmd_pop      = 1'b1;
              peek_sel_nxt = cmd.sel;
              peek_hit_nxt = (cmd.sel != 2'd3) && (fill_r[cmd.sel] != '0);
              ram_re       = 1'b1;
              ram_raddr    = entry_addr(cmd.sel, head_r[cmd.sel]);
              state_nxt    = B_PEEK_WAIT;
            end
            default: begin
              cmd_pop = 1'b1;
            end
          endcase
        end
      end
      B_PEEK_WAIT: begin
        if (out_free) begin
          load         = 1'b1;
          res_nxt      = '0;
          res_nxt.qidx = peek_sel_r;
          res_nxt.last = 1'b1;
          if (peek_hit_r) begin
            res_nxt.status = ST_PEEK_HIT;
            res_nxt.tag    = ram_rdata[ENTRY_W-1:MERIT_W];
            res_nxt.merit  = ram_rdata[MERIT_W-1:0];
          end else begin
            res_nxt.status = ST_EMPTY;
          end
          state_nxt = B_IDLE;
        end
      end
      B_DRAIN_RD: begin
        ram_re            = 1'b1;
        head_nxt[cur_q_r] = ptr_inc(head_r[cur_q_r]);
        fill_nxt[cur_q_r] = fill_r[cur_q_r] - 1'b1;
        state_nxt         = B_DRAIN_WAIT;
      end
      B_DRAIN_WAIT: begin
        if (out_free) begin
          load           = 1'b1;
          res_nxt        = '0;
          res_nxt.status = ST_DRAINED;
          res_nxt.qidx   = cur_q_r;
          res_nxt.tag    = ram_rdata[ENTRY_W-1:MERIT_W];
          res_nxt.merit  = ram_rdata[MERIT_W-1:0];
          res_nxt.last   = all_empty;
          if (all_empty) begin
            state_nxt = B_IDLE;
          end else begin
            cur_q_nxt = next_q;
            state_nxt = B_DRAIN_RD;
          end
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase

    // Fill counts as they stand after this beat.
    if (load) begin
      res_nxt.fill0 = FILL_W'(fill_nxt[0]);
      res_nxt.fill1 = FILL_W'(fill_nxt[1]);
      res_nxt.fill2 = FILL_W'(fill_nxt[2]);
    end
    out_valid_nxt = load || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      fill_r      <= '{default: '0};
      head_r      <= '{default: '0};
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_q_r    <= cur_q_nxt;
    peek_sel_r <= peek_sel_nxt;
    peek_hit_r <= peek_hit_nxt;
    res_r      <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign result    = res_r;

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r[0] <= CNT_W'(QUEUE_DEPTH)) && (fill_r[1] <= CNT_W'(QUEUE_DEPTH)) &&
    (fill_r[2] <= CNT_W'(QUEUE_DEPTH))) else $error("fill count above depth");
  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DRAIN_RD) |-> (cur_q_r != 2'd3) && (fill_r[cur_q_r] != '0))
    else $error("drain read from empty queue");
  a_last_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (res_r.status == ST_DRAINED) && res_r.last) |->
    (res_r.fill0 == '0) && (res_r.fill1 == '0) && (res_r.fill2 == '0))
    else $error("last drained beat with entries left");
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> (state_r == B_IDLE)) else $error("entry write outside add");
`endif

endmodule

// ===== rtl/core/shortest_queue_dispatch_rr_drain_unit.sv =====
// ----------------------------------------------------------------------------
// shortest_queue_dispatch_rr_drain_unit
// Join-shortest-queue dispatcher over three bounded FIFOs with peek and a
// round-robin drain of all queues.
// ----------------------------------------------------------------------------
// Adds sustain one beat per cycle while the output is not stalled. A peek
// waits for the registered read of the entry RAM; a drain steps a read and
// a wait state per entry, and the next command waits until a peek or drain ends.
// Reset: synchronous, active low; clears fill counts and head pointers, no
// clearing pass over the entry RAM, ready in the cycle after reset.
module shortest_queue_dispatch_rr_drain_unit import sqd_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // student_tag[31:0], merit[47:32], queue_select[49:48], zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // action[1:0]
  input  logic [1:0]             in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // queue_index[1:0], out_tag[33:2], out_merit[49:34], fill_zero[54:50],
  // fill_one[59:55], fill_two[64:60], zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // status[2:0]
  output logic [2:0]             out_tuser,
  output logic                   out_tlast
);

  cmd_t    in_cmd, cmd;
  logic    cmd_valid, cmd_pop;
  result_t result;

  assign in_cmd.act   = action_t'(in_tuser);
  assign in_cmd.tag   = in_tdata[31:0];
  assign in_cmd.merit = in_tdata[47:32];
  assign in_cmd.sel   = in_tdata[49:48];

  sqd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_cmd    (in_cmd),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  sqd_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .result    (result)
  );

  assign out_tdata = {7'd0, result.fill2, result.fill1, result.fill0,
                      result.merit, result.tag, result.qidx};
  assign out_tuser = result.status;
  assign out_tlast = result.last;

endmodule

// ===== verif/tb_shortest_queue_dispatch_rr_drain_unit.sv =====
// ----------------------------------------------------------------------------
// tb_shortest_queue_dispatch_rr_drain_unit
// Self-checking bench for the join-shortest-queue dispatcher. The bench
// starts with a table of directed beats, some with their result typed in.
// Random episodes of adds, peeks, drains, fill-to-full runs and noise follow.
// A queue model inside the bench predicts every result beat, and each
// received beat is compared field by field. Both stream sides idle in random
// bursts, and the sink holds off once for a long stretch to back up the block.
// ----------------------------------------------------------------------------
module tb_shortest_queue_dispatch_rr_drain_unit;
  import sqd_pkg::*;

  localparam int QDEPTH      = 16;
  localparam int ITEMS       = 370;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 30;

  typedef struct {
    action_t           act;
    logic [TAG_W-1:0]  tag;
    logic [MERIT_W-1:0] merit;
    logic [QIDX_W-1:0] sel;
    bit                pinned;
    result_t           want;
  } stim_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [1:0]             in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [2:0]             out_tuser;
  logic                   out_tlast;

  // queue model state
  logic [ENTRY_W-1:0] q_entry [NUM_QUEUES][QDEPTH];
  int                 q_head  [NUM_QUEUES];
  int                 q_fill  [NUM_QUEUES];
  result_t            pending_results[$];

  // side info riding along with the beat on the input bus
  bit                 beat_pinned;
  result_t            beat_want;

  stim_row_t          dir_table[$];
  int                 n_items;
  int                 n_errors;
  int                 n_cycles;
  bit                 src_idle_on;
  bit                 sink_idle_on;
  bit                 hold_req;

  shortest_queue_dispatch_rr_drain_unit #(
    .QUEUE_DEPTH(QDEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic result_t make_result(status_t st, logic [QIDX_W-1:0] qi,
                                          logic [TAG_W-1:0] tag,
                                          logic [MERIT_W-1:0] merit, logic lst);
    result_t r;
    r.status = st;
    r.qidx   = qi;
    r.tag    = tag;
    r.merit  = merit;
    r.fill0  = FILL_W'(q_fill[0]);
    r.fill1  = FILL_W'(q_fill[1]);
    r.fill2  = FILL_W'(q_fill[2]);
    r.last   = lst;
    return r;
  endfunction

  // Advance the queue model by one accepted beat and queue up its results.
  task automatic dispatch_predict(action_t act, logic [TAG_W-1:0] tag,
                                  logic [MERIT_W-1:0] merit, logic [QIDX_W-1:0] sel);
    int q;
    int slot;
    int left;
    logic [ENTRY_W-1:0] e;
    case (act)
      ACT_ADD: begin
        q = 0;
        if (q_fill[1] < q_fill[q]) q = 1;
        if (q_fill[2] < q_fill[q]) q = 2;
        if (q_fill[q] >= QDEPTH) begin
          pending_results.push_back(make_result(ST_REJECTED, '0, '0, '0, 1'b1));
        end else begin
          slot = (q_head[q] + q_fill[q]) % QDEPTH;
          q_entry[q][slot] = {tag, merit};
          q_fill[q]++;
          pending_results.push_back(make_result(ST_ADDED, QIDX_W'(q), '0, '0, 1'b1));
        end
      end
      ACT_DRAIN: begin
        left = q_fill[0] + q_fill[1] + q_fill[2];
        if (left == 0) begin
          pending_results.push_back(make_result(ST_EMPTY, '0, '0, '0, 1'b1));
        end
        // visit queues 0, 1, 2 in rounds, skipping the empty ones
        while (left != 0) begin
          for (q = 0; q < NUM_QUEUES; q++) begin
            if (q_fill[q] != 0) begin
              e = q_entry[q][q_head[q]];
              q_head[q] = (q_head[q] + 1) % QDEPTH;
              q_fill[q]--;
              left--;
              pending_results.push_back(make_result(ST_DRAINED, QIDX_W'(q),
                                                    e[ENTRY_W-1:MERIT_W],
                                                    e[MERIT_W-1:0], left == 0));
            end
          end
        end
      end
      ACT_PEEK: begin
        if (sel < NUM_QUEUES && q_fill[sel] != 0) begin
          e = q_entry[sel][q_head[sel]];
          pending_results.push_back(make_result(ST_PEEK_HIT, sel, e[ENTRY_W-1:MERIT_W],
                                                e[MERIT_W-1:0], 1'b1));
        end else begin
          pending_results.push_back(make_result(ST_EMPTY, sel, '0, '0, 1'b1));
        end
      end
      default: ;  // unknown action: drop, no result
    endcase
  endtask

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      dispatch_predict(action_t'(in_tuser), in_tdata[31:0], in_tdata[47:32],
                       in_tdata[49:48]);
      if (beat_pinned) begin
        void'(pending_results.pop_back());
        pending_results.push_back(beat_want);
      end
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin
    result_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: status %0d", out_tuser);
        n_errors++;
      end else begin
        w = pending_results.pop_front();
        check_field("status",      32'(w.status), 32'(out_tuser));
        check_field("queue_index", 32'(w.qidx),   32'(out_tdata[1:0]));
        check_field("out_tag",     w.tag,         out_tdata[33:2]);
        check_field("out_merit",   32'(w.merit),  32'(out_tdata[49:34]));
        check_field("fill_zero",   32'(w.fill0),  32'(out_tdata[54:50]));
        check_field("fill_one",    32'(w.fill1),  32'(out_tdata[59:55]));
        check_field("fill_two",    32'(w.fill2),  32'(out_tdata[64:60]));
        check_field("last",        32'(w.last),   32'(out_tlast));
      end
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("FAIL shortest_queue_dispatch_rr_drain_unit");
      $finish;
    end
  end

  // Sink side: random stall bursts, plus one long hold-off on request.
  initial begin
    int n;
    out_tready = 1'b0;
    while (!rst_n) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready = 1'b0;
        hold_req   = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        out_tready = 1'b0;
        n = $urandom_range(1, 16);
        repeat (n - 1) @(negedge clk);
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // Drive one beat from a falling edge and return at the falling edge after
  // it was taken. Valid stays high, so without an idle gap beats go back to back.
  task automatic push_beat(action_t act, logic [TAG_W-1:0] tag,
                           logic [MERIT_W-1:0] merit, logic [QIDX_W-1:0] sel,
                           bit pinned, result_t want);
    int gap;
    if (src_idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 16);
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid   = 1'b1;
    in_tuser    = act;
    in_tdata    = {6'd0, sel, merit, tag};
    beat_pinned = pinned;
    beat_want   = want;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (act != ACT_NONE) n_items++;
    @(negedge clk);
  endtask

  function automatic logic [TAG_W-1:0] pick_tag();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [MERIT_W-1:0] pick_merit();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return MERIT_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic push_add();
    push_beat(ACT_ADD, pick_tag(), pick_merit(), QIDX_W'($urandom_range(0, 3)), 1'b0, '0);
  endtask

  task automatic push_peek(int max_sel);
    push_beat(ACT_PEEK, pick_tag(), pick_merit(), QIDX_W'($urandom_range(0, max_sel)),
              1'b0, '0);
  endtask

  // Add until every queue is full, then overflow a few times.
  task automatic fill_to_full();
    int k;
    while (q_fill[0] + q_fill[1] + q_fill[2] < NUM_QUEUES * QDEPTH) push_add();
    k = $urandom_range(1, 3);
    repeat (k) push_add();
  endtask

  function automatic void add_row(action_t act, logic [TAG_W-1:0] tag,
                                  logic [MERIT_W-1:0] merit, logic [QIDX_W-1:0] sel,
                                  bit pinned, status_t st, logic [QIDX_W-1:0] qi,
                                  logic [TAG_W-1:0] etag, logic [MERIT_W-1:0] emerit,
                                  int f0, int f1, int f2);
    stim_row_t r;
    r.act         = act;
    r.tag         = tag;
    r.merit       = merit;
    r.sel         = sel;
    r.pinned      = pinned;
    r.want.status = st;
    r.want.qidx   = qi;
    r.want.tag    = etag;
    r.want.merit  = emerit;
    r.want.fill0  = FILL_W'(f0);
    r.want.fill1  = FILL_W'(f1);
    r.want.fill2  = FILL_W'(f2);
    r.want.last   = 1'b1;
    dir_table.push_back(r);
  endfunction

  initial begin
    stim_row_t r;
    int k;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = ACT_ADD;
    beat_pinned  = 1'b0;
    beat_want    = '0;
    n_items      = 0;
    n_errors     = 0;
    n_cycles     = 0;
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    hold_req     = 1'b0;
    for (int q = 0; q < NUM_QUEUES; q++) begin
      q_head[q] = 0;
      q_fill[q] = 0;
    end

    // act, tag, merit, sel, pinned | status, qidx, tag, merit, fills
    add_row(ACT_PEEK,  '0, '0, 2'd0, 1, ST_EMPTY, 2'd0, '0, '0, 0, 0, 0);
    add_row(ACT_DRAIN, '0, '0, 2'd0, 1, ST_EMPTY, 2'd0, '0, '0, 0, 0, 0);
    add_row(ACT_PEEK,  '0, '0, 2'd3, 1, ST_EMPTY, 2'd3, '0, '0, 0, 0, 0);
    add_row(ACT_NONE,  '1, '1, 2'd3, 0, ST_EMPTY, 2'd0, '0, '0, 0, 0, 0);
    add_row(ACT_ADD,   '1, '1, 2'd0, 1, ST_ADDED, 2'd0, '0, '0, 1, 0, 0);
    add_row(ACT_ADD,   '0, '0, 2'd3, 1, ST_ADDED, 2'd1, '0, '0, 1, 1, 0);
    add_row(ACT_ADD,   32'h1234_5678, 16'h8000, 2'd0, 1, ST_ADDED, 2'd2, '0, '0, 1, 1, 1);
    add_row(ACT_ADD,   32'hA5A5_A5A5, 16'h5A5A, 2'd1, 1, ST_ADDED, 2'd0, '0, '0, 2, 1, 1);
    add_row(ACT_PEEK,  32'hDEAD_BEEF, 16'h1234, 2'd0, 1, ST_PEEK_HIT, 2'd0, '1, '1, 2, 1, 1);
    add_row(ACT_PEEK,  '0, '0, 2'd1, 1, ST_PEEK_HIT, 2'd1, '0, '0, 2, 1, 1);
    add_row(ACT_PEEK,  '0, '0, 2'd2, 1, ST_PEEK_HIT, 2'd2, 32'h1234_5678, 16'h8000,
            2, 1, 1);
    add_row(ACT_PEEK,  '1, '1, 2'd3, 1, ST_EMPTY, 2'd3, '0, '0, 2, 1, 1);
    add_row(ACT_NONE,  32'h5555_AAAA, 16'hAA55, 2'd2, 0, ST_EMPTY, 2'd0, '0, '0, 0, 0, 0);
    add_row(ACT_ADD,   32'h0000_0001, 16'h0001, 2'd2, 1, ST_ADDED, 2'd1, '0, '0, 2, 2, 1);
    add_row(ACT_DRAIN, '1, '1, 2'd3, 0, ST_EMPTY, 2'd0, '0, '0, 0, 0, 0);
    add_row(ACT_PEEK,  '0, '0, 2'd1, 1, ST_EMPTY, 2'd1, '0, '0, 0, 0, 0);
    add_row(ACT_DRAIN, '0, '0, 2'd0, 1, ST_EMPTY, 2'd0, '0, '0, 0, 0, 0);
    add_row(ACT_ADD,   32'h5A5A_5A5A, 16'hA5A5, 2'd2, 0, ST_EMPTY, 2'd0, '0, '0, 0, 0, 0);
    add_row(ACT_PEEK,  '0, '0, 2'd0, 0, ST_EMPTY, 2'd0, '0, '0, 0, 0, 0);
    add_row(ACT_DRAIN, '0, '0, 2'd0, 0, ST_EMPTY, 2'd0, '0, '0, 0, 0, 0);

    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_table[i]) begin
      r = dir_table[i];
      push_beat(r.act, r.tag, r.merit, r.sel, r.pinned, r.want);
    end

    // Back the block up: the sink holds off while the source streams a
    // fill to full, overflow adds, a peek and a full drain.
    src_idle_on = 1'b0;
    hold_req    = 1'b1;
    fill_to_full();
    push_peek(3);
    push_beat(ACT_DRAIN, pick_tag(), pick_merit(), 2'd0, 1'b0, '0);
    src_idle_on = 1'b1;

    while (n_items < ITEMS) begin
      if (n_items > ITEMS - 60) begin
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
      end
      case ($urandom_range(0, 11))
        0, 1, 2, 3: begin
          k = $urandom_range(1, 12);
          repeat (k) begin
            if ($urandom_range(0, 3) == 0) push_peek(2);
            else push_add();
          end
        end
        4, 5: push_beat(ACT_DRAIN, pick_tag(), pick_merit(),
                        QIDX_W'($urandom_range(0, 3)), 1'b0, '0);
        6: begin
          fill_to_full();
          push_peek(3);
        end
        7: push_beat(ACT_NONE, pick_tag(), pick_merit(),
                     QIDX_W'($urandom_range(0, 3)), 1'b0, '0);
        8: push_beat(ACT_PEEK, pick_tag(), pick_merit(), 2'd3, 1'b0, '0);
        default: push_peek(2);
      endcase
    end
    in_tvalid   = 1'b0;
    beat_pinned = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (n_errors == 0) begin
      $display("PASS shortest_queue_dispatch_rr_drain_unit");
    end else begin
      $display("FAIL shortest_queue_dispatch_rr_drain_unit");
    end
    $finish;
  end

endmodule
